FILE: rtl/lz77_longest_match_finder_defines.svh
// assertion macros shared by the checker
`ifndef LZ77_LONGEST_MATCH_FINDER_DEFINES_SVH
`define LZ77_LONGEST_MATCH_FINDER_DEFINES_SVH

// same-cycle implication, off during reset
`define LZMF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define LZMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also covers reset itself
`define LZMF_ASSERT_RESET(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lzmf_pkg.sv
// types and constants of the longest match finder
package lzmf_pkg;

   localparam int BUFFER_DEPTH_DEF = 65536;

   localparam int OP_W    = 2;
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 16;
   localparam int HIST_W  = 16;
   localparam int LEN_W   = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_HISTORY_LIMIT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_MATCH_LENGTH = 2'd1;

   localparam logic [HIST_W-1:0] HISTORY_LIMIT_RST    = 16'd20000;
   localparam logic [LEN_W-1:0]  MIN_MATCH_LENGTH_RST = 17'd8;
   localparam logic [LEN_W-1:0]  LEN_CAP              = '1;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] data_byte;
      logic [POS_W-1:0]  position;
   } req_payload_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] distance;
      logic [LEN_W-1:0] match_length;
      logic             overlaps;
   } rsp_payload_type;

   typedef struct packed {
      logic idle;
      logic done;
   } srch_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAND,
      ST_RUN,
      ST_CMP,
      ST_DONE
   } srch_state_type;

endpackage

FILE: rtl/lzmf_ram.sv
// generic single write, single read ram with registered read data
module lzmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/lzmf_search.sv
// search sequencer: walks candidates and compares one byte pair per step
module lzmf_search #(
   parameter int BUFFER_DEPTH = lzmf_pkg::BUFFER_DEPTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   done_ack,
   input  logic [lzmf_pkg::POS_W-1:0]             position,
   input  logic [lzmf_pkg::HIST_W-1:0]            history_limit,
   input  logic [lzmf_pkg::LEN_W-1:0]             min_match_length,
   input  logic [$clog2(BUFFER_DEPTH+1)-1:0]      loaded_length,
   output logic [$clog2(BUFFER_DEPTH)-1:0]        cand_addr,
   output logic [$clog2(BUFFER_DEPTH)-1:0]        pos_addr,
   input  logic [lzmf_pkg::BYTE_W-1:0]            cand_byte,
   input  logic [lzmf_pkg::BYTE_W-1:0]            pos_byte,
   output lzmf_pkg::srch_status_type              status,
   output lzmf_pkg::rsp_payload_type              result
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int LW = $clog2(BUFFER_DEPTH + 1);
   localparam int CW = (LW > lzmf_pkg::LEN_W + 1) ? LW : lzmf_pkg::LEN_W + 1;

   lzmf_pkg::srch_state_type state_ff, state_in;

   logic [lzmf_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [lzmf_pkg::POS_W-1:0] cand_ff, cand_in;
   logic [lzmf_pkg::LEN_W-1:0] n_ff, n_in;
   logic [lzmf_pkg::LEN_W-1:0] best_len_ff, best_len_in;
   logic [lzmf_pkg::POS_W-1:0] best_start_ff, best_start_in;
   logic                       hit_ff, hit_in;

   logic [CW-1:0]              pos_idx;
   logic [CW-1:0]              cand_idx;
   logic                       in_range;
   logic                       cand_more;
   logic                       bytes_equal;
   logic                       end_run;
   logic                       better;
   logic [lzmf_pkg::POS_W-1:0] hist;
   logic [lzmf_pkg::POS_W-1:0] match_dist;

   assign pos_idx     = CW'(pos_ff) + CW'(n_ff);
   assign cand_idx    = CW'(cand_ff) + CW'(n_ff);
   assign in_range    = (pos_idx < CW'(loaded_length)) && (n_ff != lzmf_pkg::LEN_CAP);
   assign cand_more   = ((lzmf_pkg::LEN_W)'(cand_ff) + 1'b1) < (lzmf_pkg::LEN_W)'(pos_ff);
   assign bytes_equal = (cand_byte == pos_byte);
   assign end_run     = ((state_ff == lzmf_pkg::ST_RUN) && !in_range) ||
                        ((state_ff == lzmf_pkg::ST_CMP) && !bytes_equal);
   assign better      = (n_ff >= best_len_ff);
   assign hist        = (history_limit < position) ? history_limit : position;

   // both indexes stay below the loaded end whenever the read is used
   assign cand_addr = cand_idx[AW-1:0];
   assign pos_addr  = pos_idx[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzmf_pkg::ST_IDLE: begin
            if (start) begin
               state_in = lzmf_pkg::ST_CAND;
            end
         end
         lzmf_pkg::ST_CAND: begin
            state_in = cand_more ? lzmf_pkg::ST_RUN : lzmf_pkg::ST_DONE;
         end
         lzmf_pkg::ST_RUN: begin
            state_in = in_range ? lzmf_pkg::ST_CMP : lzmf_pkg::ST_CAND;
         end
         lzmf_pkg::ST_CMP: begin
            state_in = bytes_equal ? lzmf_pkg::ST_RUN : lzmf_pkg::ST_CAND;
         end
         lzmf_pkg::ST_DONE: begin
            if (done_ack) begin
               state_in = lzmf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lzmf_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      pos_in        = pos_ff;
      cand_in       = cand_ff;
      n_in          = n_ff;
      best_len_in   = best_len_ff;
      best_start_in = best_start_ff;
      hit_in        = hit_ff;
      if ((state_ff == lzmf_pkg::ST_IDLE) && start) begin
         pos_in        = position;
         cand_in       = position - hist;
         best_len_in   = min_match_length;
         best_start_in = '0;
         hit_in        = 1'b0;
      end
      if (state_ff == lzmf_pkg::ST_CAND) begin
         n_in = '0;
      end
      if ((state_ff == lzmf_pkg::ST_CMP) && bytes_equal) begin
         n_in = n_ff + 1'b1;
      end
      if (end_run) begin
         // ties go to the later start
         if (better) begin
            best_len_in   = n_ff;
            best_start_in = cand_ff;
            hit_in        = 1'b1;
         end
         cand_in = cand_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzmf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      pos_ff        <= pos_in;
      cand_ff       <= cand_in;
      n_ff          <= n_in;
      best_len_ff   <= best_len_in;
      best_start_ff <= best_start_in;
      hit_ff        <= hit_in;
   end

   // outputs
   assign match_dist = pos_ff - best_start_ff;

   always_comb begin
      status.idle = (state_ff == lzmf_pkg::ST_IDLE);
      status.done = (state_ff == lzmf_pkg::ST_DONE);
      result.found        = hit_ff;
      result.distance     = hit_ff ? match_dist : '0;
      result.match_length = hit_ff ? best_len_ff : '0;
      result.overlaps     = hit_ff && (best_len_ff > (lzmf_pkg::LEN_W)'(match_dist));
   end

endmodule

FILE: rtl/lz77_longest_match_finder.sv
// top level of the longest match finder: buffer, registers, result register
//
// req channel: one word per request; op selects clear, append byte or search.
// clear and append finish in the cycle they are accepted and give no response.
// a search gives exactly one rsp word: found, distance, match_length, overlaps.
// csr channel: always ready; index 0 is history_limit, index 1 is
// min_match_length, other indexes are dropped. write only while idle.
// a search walks each candidate through a setup state, then alternates read and
// compare states along its run, and ends in a done state that loads the result
// register; candidates run from position minus the history window up to
// position minus two. each run step is one read of the two buffer copies and
// one byte compare in the shared sequencer. req_ready is low for the whole
// search. the result sits in an output register: a new request is taken while
// it waits; a later search that finishes before rsp_ready holds in its done
// state. reset empties the buffer count, restores the register defaults and
// drops any pending response; buffer bytes are not cleared.
module lz77_longest_match_finder #(
   parameter int BUFFER_DEPTH = lzmf_pkg::BUFFER_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lzmf_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lzmf_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lzmf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lzmf_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int LW = $clog2(BUFFER_DEPTH + 1);

   logic [LW-1:0]                   loaded_ff, loaded_in;
   logic [lzmf_pkg::HIST_W-1:0]     hist_limit_ff, hist_limit_in;
   logic [lzmf_pkg::LEN_W-1:0]      min_len_ff, min_len_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   lzmf_pkg::rsp_payload_type       rsp_payload_ff, rsp_payload_in;

   logic                            req_fire;
   logic                            csr_fire;
   logic                            start;
   logic                            wr_en;
   logic                            rsp_load;
   logic [AW-1:0]                   cand_addr;
   logic [AW-1:0]                   pos_addr;
   logic [lzmf_pkg::BYTE_W-1:0]     cand_byte;
   logic [lzmf_pkg::BYTE_W-1:0]     pos_byte;
   lzmf_pkg::srch_status_type       status;
   lzmf_pkg::rsp_payload_type       result;

   assign req_ready = status.idle;
   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign start     = req_fire && (req_payload.op == lzmf_pkg::OP_SEARCH);
   // a full buffer drops the byte
   assign wr_en     = req_fire && (req_payload.op == lzmf_pkg::OP_APPEND) &&
                      (loaded_ff < LW'(BUFFER_DEPTH));
   assign rsp_load  = status.done && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      loaded_in = loaded_ff;
      if (req_fire && (req_payload.op == lzmf_pkg::OP_CLEAR)) begin
         loaded_in = '0;
      end else if (wr_en) begin
         loaded_in = loaded_ff + 1'b1;
      end
   end

   always_comb begin
      hist_limit_in = hist_limit_ff;
      min_len_in    = min_len_ff;
      if (csr_fire) begin
         case (csr_index)
            lzmf_pkg::CSR_HISTORY_LIMIT: begin
               hist_limit_in = csr_wdata[lzmf_pkg::HIST_W-1:0];
            end
            lzmf_pkg::CSR_MIN_MATCH_LENGTH: begin
               min_len_in = csr_wdata[lzmf_pkg::LEN_W-1:0];
            end
            default: begin
               hist_limit_in = hist_limit_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_payload_in = rsp_payload_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      if (rsp_load) begin
         rsp_payload_in = result;
         rsp_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff     <= '0;
         hist_limit_ff <= lzmf_pkg::HISTORY_LIMIT_RST;
         min_len_ff    <= lzmf_pkg::MIN_MATCH_LENGTH_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         loaded_ff     <= loaded_in;
         hist_limit_ff <= hist_limit_in;
         min_len_ff    <= min_len_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // two copies of the buffer so candidate and position bytes read together
   lzmf_ram #(
      .WIDTH (lzmf_pkg::BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_cand_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (loaded_ff[AW-1:0]),
      .wr_data (req_payload.data_byte),
      .rd_addr (cand_addr),
      .rd_data (cand_byte)
   );

   lzmf_ram #(
      .WIDTH (lzmf_pkg::BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_pos_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (loaded_ff[AW-1:0]),
      .wr_data (req_payload.data_byte),
      .rd_addr (pos_addr),
      .rd_data (pos_byte)
   );

   lzmf_search #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_search (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .done_ack         (rsp_load),
      .position         (req_payload.position),
      .history_limit    (hist_limit_ff),
      .min_match_length (min_len_ff),
      .loaded_length    (loaded_ff),
      .cand_addr        (cand_addr),
      .pos_addr         (pos_addr),
      .cand_byte        (cand_byte),
      .pos_byte         (pos_byte),
      .status           (status),
      .result           (result)
   );

endmodule

FILE: rtl/lzmf_checker.sv
// port-level checks on the response channel, bound to the top level
`include "lz77_longest_match_finder_defines.svh"

module lzmf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input lzmf_pkg::rsp_payload_type rsp_payload
);

   `LZMF_ASSERT_RESET(a_reset_no_rsp, clock, reset, !rsp_valid, "response valid after reset")

   `LZMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled response changed")

   `LZMF_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_payload.found, rsp_payload.distance == '0 && rsp_payload.match_length == '0 && !rsp_payload.overlaps, "miss with nonzero fields")

   `LZMF_ASSERT_NOW(a_hit_dist, clock, reset, rsp_valid && rsp_payload.found, rsp_payload.distance >= 16'd2, "match closer than two bytes")

   `LZMF_ASSERT_NOW(a_overlap, clock, reset, rsp_valid && rsp_payload.overlaps, rsp_payload.found && (rsp_payload.match_length > 17'(rsp_payload.distance)), "overlap flag inconsistent")

endmodule

bind lz77_longest_match_finder lzmf_checker u_lzmf_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

FILE: sim/lzmf_match_checker.sv
// checker for the longest match finder: shadow buffer, search prediction, response compare
module lzmf_match_checker
   import lzmf_pkg::*;
#(
   parameter int DEPTH = BUFFER_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_payload_type       req_payload,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_payload_type       rsp_payload,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    pending
);

   logic [BYTE_W-1:0] shadow_bytes [0:DEPTH-1];
   int                shadow_loaded;
   logic [HIST_W-1:0] shadow_hist;
   logic [LEN_W-1:0]  shadow_min_len;
   rsp_payload_type   expected_matches [$];

   // walk every candidate start in the window, later start wins a tie
   function automatic rsp_payload_type predict_search(input logic [POS_W-1:0] pos);
      int              span;
      int              cand;
      int              run;
      int              best_len;
      int              best_start;
      bit              hit;
      rsp_payload_type r;
      span = (shadow_hist < pos) ? int'(shadow_hist) : int'(pos);
      best_len = shadow_min_len;
      best_start = 0;
      hit = 1'b0;
      for (cand = pos - span; cand + 1 < pos; cand++) begin
         run = 0;
         while (pos + run < shadow_loaded &&
                shadow_bytes[cand + run] == shadow_bytes[pos + run])
            run++;
         if (run >= best_len) begin
            best_len = run;
            best_start = cand;
            hit = 1'b1;
         end
      end
      r = '0;
      if (hit) begin
         r.found = 1'b1;
         r.distance = POS_W'(pos - best_start);
         r.match_length = LEN_W'(best_len);
         r.overlaps = (best_len > pos - best_start);
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      rsp_payload_type want;
      bit              bad;
      if (reset) begin
         shadow_loaded = 0;
         shadow_hist = HISTORY_LIMIT_RST;
         shadow_min_len = MIN_MATCH_LENGTH_RST;
         expected_matches.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_matches.size() == 0) begin
               $display("%0t: response word with no search pending, expected none got %h",
                        $time, rsp_payload);
               mismatch_count++;
            end else begin
               want = expected_matches.pop_front();
               bad = 1'b0;
               if (rsp_payload.found !== want.found) begin
                  $display("%0t: found expected %0d got %0d",
                           $time, want.found, rsp_payload.found);
                  bad = 1'b1;
               end
               if (rsp_payload.distance !== want.distance) begin
                  $display("%0t: distance expected %0d got %0d",
                           $time, want.distance, rsp_payload.distance);
                  bad = 1'b1;
               end
               if (rsp_payload.match_length !== want.match_length) begin
                  $display("%0t: match_length expected %0d got %0d",
                           $time, want.match_length, rsp_payload.match_length);
                  bad = 1'b1;
               end
               if (rsp_payload.overlaps !== want.overlaps) begin
                  $display("%0t: overlaps expected %0d got %0d",
                           $time, want.overlaps, rsp_payload.overlaps);
                  bad = 1'b1;
               end
               if (bad)
                  mismatch_count++;
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HISTORY_LIMIT:    shadow_hist = csr_wdata[HIST_W-1:0];
               CSR_MIN_MATCH_LENGTH: shadow_min_len = csr_wdata;
               default: ;
            endcase
         end
         // request effects land after the response compare, which is always older
         if (req_valid && req_ready) begin
            case (req_payload.op)
               OP_CLEAR: shadow_loaded = 0;
               OP_APPEND: begin
                  if (shadow_loaded < DEPTH) begin
                     shadow_bytes[shadow_loaded] = req_payload.data_byte;
                     shadow_loaded++;
                  end
               end
               OP_SEARCH: expected_matches.push_back(predict_search(req_payload.position));
               default: ;
            endcase
         end
      end
      pending = expected_matches.size();
   end

endmodule

FILE: sim/tb.sv
// testbench top for the longest match finder: clock, reset, stimulus and verdict
module tb;
   import lzmf_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT   = 3000000;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 50;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_payload_type       rsp_payload;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count;
   int pending_results;
   int cycle_count = 0;
   int burst_left = 0;
   bit steady = 1'b0;
   int fill_count = 0;
   int hold_req = 0;
   int hold_seen = 0;
   logic [15:0] stall_pattern = 16'hFFFF;
   int stall_phase = 0;

   lz77_longest_match_finder uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   lzmf_match_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending        (pending_results)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** lz77_longest_match_finder: FAILED **");
         $finish;
      end
   end

   // response side: rotating stall pattern, plus a long hold-off on request
   always begin
      @(negedge clock);
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         rsp_ready <= 1'b0;
         repeat (HOLD_CYCLES) @(negedge clock);
      end else begin
         if (stall_phase == 0)
            stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
         rsp_ready <= stall_pattern[stall_phase];
         stall_phase = (stall_phase + 1) % 16;
      end
   end

   // called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                            input logic [POS_W-1:0] pos);
      req_payload_type w;
      w.op = op;
      w.data_byte = data;
      w.position = pos;
      if (burst_left == 0 && !steady) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_payload <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0)
         burst_left--;
      if (op == OP_CLEAR)
         fill_count = 0;
      else if (op == OP_APPEND && fill_count < BUFFER_DEPTH_DEF)
         fill_count++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic set_window(input logic [HIST_W-1:0] hist, input logic [LEN_W-1:0] min_len);
      wait_idle();
      for (int k = 0; k < 2; k++) begin
         csr_valid <= 1'b1;
         csr_index <= (k == 0) ? CSR_HISTORY_LIMIT : CSR_MIN_MATCH_LENGTH;
         csr_wdata <= (k == 0) ? {1'b0, hist} : min_len;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // mostly a small alphabet around a random base so searches actually find matches
   task automatic random_phase(input logic [HIST_W-1:0] hist, input logic [LEN_W-1:0] min_len,
                               input int words);
      int               count;
      int               sel;
      logic [BYTE_W-1:0] base;
      bit               wide;
      logic [POS_W-1:0] pos;
      set_window(hist, min_len);
      base = 8'($urandom);
      wide = ($urandom_range(0, 3) == 0);
      count = 0;
      while (count < words) begin
         sel = $urandom_range(0, 99);
         if (fill_count > 60 || sel < 4) begin
            send_word(OP_CLEAR, 8'($urandom), 16'($urandom));
            count++;
         end else if (sel < 12) begin
            send_word(OP_UNUSED, 8'($urandom), 16'($urandom));
         end else if (fill_count < 6 || sel < 55) begin
            send_word(OP_APPEND, wide ? 8'($urandom) : base ^ 8'($urandom_range(0, 3)),
                      16'($urandom));
            count++;
         end else begin
            if (hist <= 64 && $urandom_range(0, 9) == 0)
               pos = 16'($urandom);
            else
               pos = 16'($urandom_range(0, fill_count + 3));
            send_word(OP_SEARCH, 8'($urandom), pos);
            count++;
         end
      end
   endtask

   initial begin : stimulus
      int i;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_HISTORY_LIMIT;
      csr_wdata = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // widest window, minimum of one
      set_window(16'hFFFF, 17'd1);
      send_word(OP_SEARCH, 8'hFF, 16'd0);
      send_word(OP_UNUSED, 8'hFF, 16'hFFFF);
      for (i = 0; i < 6; i++)
         send_word(OP_APPEND, (i % 2) ? 8'hFF : 8'h00, 16'($urandom));
      send_word(OP_APPEND, 8'h5A, 16'hFFFF);
      send_word(OP_SEARCH, 8'h00, 16'd2);
      send_word(OP_SEARCH, 8'h00, 16'hFFFF);
      send_word(OP_SEARCH, 8'hA5, 16'd6);
      send_word(OP_CLEAR, 8'hFF, 16'hFFFF);
      send_word(OP_SEARCH, 8'h00, 16'd2);

      // narrowest window, longest minimum
      set_window(16'd1, 17'h10000);
      for (i = 0; i < 4; i++)
         send_word(OP_APPEND, 8'hA5, 16'd0);
      send_word(OP_SEARCH, 8'h00, 16'd3);
      send_word(OP_SEARCH, 8'h00, 16'd2);

      // zero minimum: closest candidate always qualifies
      set_window(16'd3, 17'd0);
      send_word(OP_SEARCH, 8'h00, 16'd3);
      send_word(OP_SEARCH, 8'h00, 16'd1);
      send_word(OP_SEARCH, 8'h00, 16'd200);

      // back to back appends of a short repeating pattern
      set_window(16'd12, 17'd2);
      send_word(OP_CLEAR, 8'h00, 16'd0);
      steady = 1'b1;
      for (i = 0; i < 12; i++)
         send_word(OP_APPEND, 8'((i % 5) * 8'h33), 16'($urandom));
      steady = 1'b0;
      send_word(OP_SEARCH, 8'h00, 16'd65530);
      send_word(OP_SEARCH, 8'h00, 16'hFFFF);
      send_word(OP_SEARCH, 8'h00, 16'd10);
      send_word(OP_CLEAR, 8'h00, 16'd0);

      random_phase(16'd4, 17'd1, 8);
      random_phase(16'hFFFF, 17'd3, 10);
      random_phase(16'($urandom_range(2, 40)), 17'($urandom_range(1, 5)), 10);

      // hold the response side off while searches keep coming
      wait_idle();
      hold_req++;
      for (i = 0; i < 8; i++)
         send_word(OP_SEARCH, 8'($urandom), 16'($urandom_range(0, fill_count + 2)));

      random_phase(16'd2, 17'd2, 8);
      random_phase(16'($urandom_range(1, 64)), 17'd0, 8);
      random_phase(16'($urandom_range(8, 64)), 17'($urandom_range(1, 4)), 10);

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && pending_results == 0) begin
         $display("** lz77_longest_match_finder: PASSED **");
      end else begin
         $display("** lz77_longest_match_finder: FAILED **");
      end
      $finish;
   end

endmodule
